// File: hdl/mfps_pkg.sv
// Shared constants and types for the minimum falling path sum block.
package mfps_pkg;

   localparam int DEF_MAX_COLUMNS  = 128;
   localparam int DEF_MAX_ROWS     = 256;
   localparam int DEF_ELEMENT_BITS = 16;

   localparam int SUM_BITS          = 24;
   localparam int ROW_CFG_BITS      = 9;
   localparam int COLUMN_CFG_BITS   = 8;
   localparam int CSR_INDEX_BITS    = 4;
   localparam int CSR_DATA_BITS     = 9;

   localparam logic signed [SUM_BITS-1:0] SUM_MAX = {1'b0, {(SUM_BITS-1){1'b1}}};
   localparam logic signed [SUM_BITS-1:0] SUM_MIN = {1'b1, {(SUM_BITS-1){1'b0}}};

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_ROW_COUNT    = 4'd0,
      CSR_COLUMN_COUNT = 4'd1
   } csr_index_type;

   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } buf_ctrl_type;

endpackage

// File: hdl/mfps_row_buf.sv
// One-row path sum buffer: one write port, two registered read ports with write forwarding.
module mfps_row_buf #(
   parameter int MAX_COLUMNS = mfps_pkg::DEF_MAX_COLUMNS,
   parameter int ADDR_BITS   = 7
) (
   input  logic                          clock,
   input  logic                          reset,
   input  mfps_pkg::buf_ctrl_type        ctrl,
   input  logic [ADDR_BITS-1:0]          wr_addr,
   input  logic [mfps_pkg::SUM_BITS-1:0] wr_data,
   input  logic [ADDR_BITS-1:0]          rd_addr_a,
   input  logic [ADDR_BITS-1:0]          rd_addr_b,
   output logic [mfps_pkg::SUM_BITS-1:0] rd_data_a,
   output logic [mfps_pkg::SUM_BITS-1:0] rd_data_b
);
   import mfps_pkg::*;

   logic [SUM_BITS-1:0] row_sums_ff [MAX_COLUMNS];
   logic [SUM_BITS-1:0] rd_a_ff;
   logic [SUM_BITS-1:0] rd_b_ff;
   logic [SUM_BITS-1:0] fwd_data_ff;
   logic                hit_a_ff;
   logic                hit_b_ff;
   logic                hit_a_in;
   logic                hit_b_in;

   always_ff @(posedge clock) begin
      if (ctrl.wr_en) begin
         row_sums_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.rd_en) begin
         rd_a_ff     <= row_sums_ff[rd_addr_a];
         rd_b_ff     <= row_sums_ff[rd_addr_b];
         fwd_data_ff <= wr_data;
      end
   end

   // forward a write that lands at the same edge as the read
   always_comb begin
      hit_a_in = hit_a_ff;
      hit_b_in = hit_b_ff;
      if (ctrl.rd_en) begin
         hit_a_in = ctrl.wr_en && (wr_addr == rd_addr_a);
         hit_b_in = ctrl.wr_en && (wr_addr == rd_addr_b);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_a_ff <= 1'b0;
         hit_b_ff <= 1'b0;
      end else begin
         hit_a_ff <= hit_a_in;
         hit_b_ff <= hit_b_in;
      end
   end

   assign rd_data_a = hit_a_ff ? fwd_data_ff : rd_a_ff;
   assign rd_data_b = hit_b_ff ? fwd_data_ff : rd_b_ff;

endmodule

// File: hdl/min_falling_path_sum.sv
// Minimum falling path sum over a streamed matrix, one element per cycle while not stalled.
//
//  channel | direction | ports                                  | transfer
//  req     | in        | req_valid, req_stall, req_element_value | valid & !stall
//  rsp     | out       | rsp_valid, rsp_stall, rsp_min_path_sum  | valid & !stall
//  csr     | in        | csr_valid, csr_ready, csr_index, csr_data | valid & ready
//
// One element per cycle sustained unless a held result stalls the compute stage.
// Each element reads its center and right neighbor from the row buffer at accept and
// writes its sum back as it leaves the compute stage; results pass the result register.
// Reset clears positions and sets both counts to one; the buffer needs no clearing pass.
// A held result stalls the compute stage only when a second matrix finishes behind it.
module min_falling_path_sum #(
   parameter int MAX_COLUMNS  = mfps_pkg::DEF_MAX_COLUMNS,
   parameter int MAX_ROWS     = mfps_pkg::DEF_MAX_ROWS,
   parameter int ELEMENT_BITS = mfps_pkg::DEF_ELEMENT_BITS
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [ELEMENT_BITS-1:0]       req_element_value,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [mfps_pkg::SUM_BITS-1:0] rsp_min_path_sum,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [mfps_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [mfps_pkg::CSR_DATA_BITS-1:0]   csr_data
);
   import mfps_pkg::*;

   localparam int POS_BITS    = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
   localparam int COLCNT_BITS = $clog2(MAX_COLUMNS + 1);
   localparam int RPOS_BITS   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int ROWCNT_BITS = $clog2(MAX_ROWS + 1);
   localparam int ADD_BITS    = ((ELEMENT_BITS > SUM_BITS) ? ELEMENT_BITS : SUM_BITS) + 1;
   localparam logic signed [ADD_BITS-1:0] SAT_HI = ADD_BITS'(SUM_MAX);
   localparam logic signed [ADD_BITS-1:0] SAT_LO = ADD_BITS'(SUM_MIN);

   // configuration
   logic [ROW_CFG_BITS-1:0]    row_cfg_ff;
   logic [COLUMN_CFG_BITS-1:0] col_cfg_ff;
   logic [31:0]                row_cfg_wide;
   logic [31:0]                col_cfg_wide;
   logic [ROWCNT_BITS-1:0]     rows_eff;
   logic [COLCNT_BITS-1:0]     cols_eff;

   // accept stage
   logic                   accept;
   logic [POS_BITS-1:0]    col_pos_ff;
   logic [POS_BITS-1:0]    col_pos_in;
   logic [RPOS_BITS-1:0]   row_pos_ff;
   logic [RPOS_BITS-1:0]   row_pos_in;
   logic [POS_BITS-1:0]    cur_j;
   logic [COLCNT_BITS-1:0] j_next;
   logic [ROWCNT_BITS-1:0] row_next;
   logic                   cur_last_col;
   logic                   cur_last_row;

   // compute stage
   logic                           s1_valid_ff;
   logic                           s1_valid_in;
   logic signed [ELEMENT_BITS-1:0] s1_value_ff;
   logic [POS_BITS-1:0]            s1_j_ff;
   logic                           s1_first_row_ff;
   logic                           s1_last_col_ff;
   logic                           s1_emit_ff;
   logic                           s1_go;
   logic signed [SUM_BITS-1:0]     held_ff;
   logic signed [SUM_BITS-1:0]     held_in;
   logic signed [SUM_BITS-1:0]     min_ff;
   logic signed [SUM_BITS-1:0]     min_in;
   logic signed [SUM_BITS-1:0]     min_new;
   logic signed [SUM_BITS-1:0]     center;
   logic signed [SUM_BITS-1:0]     right;
   logic signed [SUM_BITS-1:0]     best;
   logic signed [ADD_BITS-1:0]     raw_sum;
   logic signed [SUM_BITS-1:0]     sum;
   logic [SUM_BITS-1:0]            rd_center;
   logic [SUM_BITS-1:0]            rd_right;
   buf_ctrl_type                   buf_ctrl;

   // result register
   logic                       rsp_valid_ff;
   logic                       rsp_valid_in;
   logic signed [SUM_BITS-1:0] rsp_sum_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_cfg_ff <= ROW_CFG_BITS'(1);
         col_cfg_ff <= COLUMN_CFG_BITS'(1);
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_ROW_COUNT: begin
               row_cfg_ff <= csr_data[ROW_CFG_BITS-1:0];
            end
            CSR_COLUMN_COUNT: begin
               col_cfg_ff <= csr_data[COLUMN_CFG_BITS-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      row_cfg_wide = 32'(row_cfg_ff);
      col_cfg_wide = 32'(col_cfg_ff);
      if (row_cfg_wide == 32'd0) begin
         rows_eff = ROWCNT_BITS'(1);
      end else if (row_cfg_wide > 32'(MAX_ROWS)) begin
         rows_eff = ROWCNT_BITS'(MAX_ROWS);
      end else begin
         rows_eff = ROWCNT_BITS'(row_cfg_wide);
      end
      if (col_cfg_wide == 32'd0) begin
         cols_eff = COLCNT_BITS'(1);
      end else if (col_cfg_wide > 32'(MAX_COLUMNS)) begin
         cols_eff = COLCNT_BITS'(MAX_COLUMNS);
      end else begin
         cols_eff = COLCNT_BITS'(col_cfg_wide);
      end
   end

   // position of the arriving element, with the column clamped to the current matrix width
   always_comb begin
      if (COLCNT_BITS'(col_pos_ff) >= cols_eff) begin
         cur_j = POS_BITS'(cols_eff - COLCNT_BITS'(1));
      end else begin
         cur_j = col_pos_ff;
      end
      j_next       = COLCNT_BITS'(cur_j) + COLCNT_BITS'(1);
      cur_last_col = (j_next >= cols_eff);
      row_next     = ROWCNT_BITS'(row_pos_ff) + ROWCNT_BITS'(1);
      cur_last_row = (row_next >= rows_eff);
   end

   assign s1_go     = s1_valid_ff && !(s1_emit_ff && rsp_valid_ff && rsp_stall);
   assign req_stall = s1_valid_ff && !s1_go;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      col_pos_in = col_pos_ff;
      row_pos_in = row_pos_ff;
      if (accept) begin
         if (cur_last_col) begin
            col_pos_in = '0;
            row_pos_in = cur_last_row ? '0 : RPOS_BITS'(row_next);
         end else begin
            col_pos_in = POS_BITS'(j_next);
         end
      end
   end

   assign s1_valid_in = accept || (s1_valid_ff && !s1_go);

   always_ff @(posedge clock) begin
      if (reset) begin
         col_pos_ff  <= '0;
         row_pos_ff  <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         col_pos_ff  <= col_pos_in;
         row_pos_ff  <= row_pos_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_value_ff     <= req_element_value;
         s1_j_ff         <= cur_j;
         s1_first_row_ff <= (row_pos_ff == '0);
         s1_last_col_ff  <= cur_last_col;
         s1_emit_ff      <= cur_last_col && cur_last_row;
      end
   end

   assign buf_ctrl.wr_en = s1_go;
   assign buf_ctrl.rd_en = accept;

   mfps_row_buf #(
      .MAX_COLUMNS (MAX_COLUMNS),
      .ADDR_BITS   (POS_BITS)
   ) u_row_buf (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (buf_ctrl),
      .wr_addr   (s1_j_ff),
      .wr_data   (sum),
      .rd_addr_a (cur_j),
      .rd_addr_b (cur_last_col ? cur_j : POS_BITS'(j_next)),
      .rd_data_a (rd_center),
      .rd_data_b (rd_right)
   );

   // three-way minimum, add, saturate and track the running row minimum
   always_comb begin
      center = $signed(rd_center);
      right  = $signed(rd_right);
      best   = center;
      if ((s1_j_ff != '0) && (held_ff < best)) begin
         best = held_ff;
      end
      if (!s1_last_col_ff && (right < best)) begin
         best = right;
      end
      if (s1_first_row_ff) begin
         raw_sum = ADD_BITS'(s1_value_ff);
      end else begin
         raw_sum = ADD_BITS'(s1_value_ff) + ADD_BITS'(best);
      end
      if (raw_sum > SAT_HI) begin
         sum = SUM_MAX;
      end else if (raw_sum < SAT_LO) begin
         sum = SUM_MIN;
      end else begin
         sum = SUM_BITS'(raw_sum);
      end
      if ((s1_j_ff == '0) || (sum < min_ff)) begin
         min_new = sum;
      end else begin
         min_new = min_ff;
      end
      held_in = held_ff;
      min_in  = min_ff;
      if (s1_go) begin
         held_in = s1_last_col_ff ? '0 : center;
         min_in  = s1_last_col_ff ? SUM_MAX : min_new;
      end
   end

   assign rsp_valid_in = (s1_go && s1_emit_ff) || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff      <= '0;
         min_ff       <= SUM_MAX;
         rsp_valid_ff <= 1'b0;
      end else begin
         held_ff      <= held_in;
         min_ff       <= min_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_go && s1_emit_ff) begin
         rsp_sum_ff <= min_new;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_min_path_sum = rsp_sum_ff;

endmodule
